### rtl/core/nss_pkg.sv
// Shared types and constants for the nearest segment search block.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nss_pkg;

  localparam int unsigned MAX_SEGMENTS = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned LIMIT_W      = 23;
  localparam int unsigned OUT_IDX_W    = 10;

  // datapath widths of the projection unit
  localparam int unsigned DIFF_W    = COORD_W + 1;       // coordinate difference
  localparam int unsigned MUL_W     = DIFF_W + 1;        // signed multiplier operand
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned LEN_W     = 2 * DIFF_W + 1;    // squared length / distance
  localparam int unsigned DOT_W     = PROD_W;
  localparam int unsigned QUOT_W    = DIFF_W;            // quotient bits 32..0
  localparam int unsigned NUM_W     = LEN_W + QUOT_W - 1;
  localparam int unsigned DIV_CNT_W = $clog2(QUOT_W);
  localparam int unsigned STEP_W    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000);
  localparam logic [COORD_W-1:0] NO_POINT    = COORD_W'(-256);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] ax;
  } seg_t;

  typedef struct packed {
    logic                      done;
    logic signed [DIFF_W-1:0]  near_x;
    logic signed [DIFF_W-1:0]  near_y;
    logic        [LEN_W-1:0]   dist2;
  } proj_rsp_t;

endpackage

`default_nettype wire

### rtl/core/nss_if.sv
// Channel interfaces of the nearest segment search block: request, result
// and configuration write. Depends on nss_pkg.
`default_nettype none

interface nss_in_if;
  import nss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  modport source (output valid, kind, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, kind, first_x, first_y, second_x, second_y, output ready);
endinterface

interface nss_out_if;
  import nss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] near_x;
  logic signed [COORD_W-1:0] near_y;
  logic [OUT_IDX_W-1:0]      near_index;
  logic [OUT_IDX_W-1:0]      exact_index;
  logic                      exact_found;
  logic                      table_empty;
  logic                      beyond_limit;
  logic                      overflowed;
  modport source (output valid, near_x, near_y, near_index, exact_index, exact_found,
                  table_empty, beyond_limit, overflowed, input ready);
  modport sink   (input valid, near_x, near_y, near_index, exact_index, exact_found,
                  table_empty, beyond_limit, overflowed, output ready);
endinterface

interface nss_cfg_if;
  import nss_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] distance_limit;
  modport source (output valid, distance_limit, input ready);
  modport sink   (input valid, distance_limit, output ready);
endinterface

`default_nettype wire

### rtl/core/nss_seg_mem.sv
// Segment table: one write port, one registered read port.
// Depends on nss_pkg.
`default_nettype none

module nss_seg_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [nss_pkg::IDX_W-1:0]  waddr_i,
  input  nss_pkg::seg_t              wdata_i,
  input  logic                       re_i,
  input  logic [nss_pkg::IDX_W-1:0]  raddr_i,
  output nss_pkg::seg_t              rdata_o
);
  import nss_pkg::*;

  seg_t mem_q [MAX_SEGMENTS];
  seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/nss_proj.sv
// Projection unit: clamped projection of a point onto one segment and the
// squared distance, over a shared multiplier and a bit-serial divider.
// Depends on nss_pkg.
`default_nettype none

module nss_proj (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  nss_pkg::seg_t                      seg_i,
  input  logic signed [nss_pkg::COORD_W-1:0] px_i,
  input  logic signed [nss_pkg::COORD_W-1:0] py_i,
  output nss_pkg::proj_rsp_t                 rsp_o
);
  import nss_pkg::*;

  typedef enum logic [7:0] {
    P_IDLE = 8'b0000_0001,
    P_MUL  = 8'b0000_0010,
    P_CHK  = 8'b0000_0100,
    P_NUM  = 8'b0000_1000,
    P_DIV  = 8'b0001_0000,
    P_RND  = 8'b0010_0000,
    P_ADD  = 8'b0100_0000,
    P_DIST = 8'b1000_0000
  } pstate_e;

  pstate_e                  st_q;
  logic [STEP_W-1:0]        sc_q;
  logic [DIV_CNT_W-1:0]     dc_q;
  logic                     done_q;
  logic signed [DIFF_W-1:0] ax_q, ay_q, bx_q, by_q, dx_q, dy_q, ux_q, uy_q;
  logic signed [DIFF_W-1:0] nx_q, ny_q;
  logic [LEN_W-1:0]         len2_q, d2_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [NUM_W-1:0]         remx_q, remy_q, dv_q;
  logic [QUOT_W-1:0]        qx_q, qy_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [DIFF_W-1:0]        magx, magy;
  logic signed [DIFF_W-1:0] ex, ey;
  logic                     gex, gey;

  assign magx = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
  assign magy = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
  assign ex   = {px_i[COORD_W-1], px_i} - nx_q;
  assign ey   = {py_i[COORD_W-1], py_i} - ny_q;
  assign gex  = (remx_q >= dv_q);
  assign gey  = (remy_q >= dv_q);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      P_MUL: begin
        unique case (sc_q)
          3'd0:    begin mul_a = MUL_W'(dx_q); mul_b = MUL_W'(dx_q); end
          3'd1:    begin mul_a = MUL_W'(dy_q); mul_b = MUL_W'(dy_q); end
          3'd2:    begin mul_a = MUL_W'(ux_q); mul_b = MUL_W'(dx_q); end
          3'd3:    begin mul_a = MUL_W'(uy_q); mul_b = MUL_W'(dy_q); end
          default: ;
        endcase
      end
      P_NUM: begin
        unique case (sc_q)
          3'd0:    begin mul_a = {1'b0, dot_q[DIFF_W-1:0]};          mul_b = {1'b0, magx}; end
          3'd1:    begin mul_a = {1'b0, dot_q[2*DIFF_W-1:DIFF_W]};   mul_b = {1'b0, magx}; end
          3'd2:    begin mul_a = {1'b0, dot_q[DIFF_W-1:0]};          mul_b = {1'b0, magy}; end
          3'd3:    begin mul_a = {1'b0, dot_q[2*DIFF_W-1:DIFF_W]};   mul_b = {1'b0, magy}; end
          default: ;
        endcase
      end
      P_DIST: begin
        unique case (sc_q)
          3'd0:    begin mul_a = MUL_W'(ex); mul_b = MUL_W'(ex); end
          3'd1:    begin mul_a = MUL_W'(ey); mul_b = MUL_W'(ey); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= P_IDLE;
      sc_q   <= '0;
      dc_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        P_IDLE: begin
          if (start_i) begin
            sc_q <= '0;
            st_q <= P_MUL;
          end
        end
        P_MUL: begin
          sc_q <= sc_q + STEP_W'(1);
          if (sc_q == STEP_W'(4)) begin
            sc_q <= '0;
            st_q <= P_CHK;
          end
        end
        P_CHK: begin
          if (len2_q == '0 || dot_q[DOT_W-1] || dot_q == '0 ||
              $unsigned(dot_q) >= DOT_W'(len2_q)) begin
            st_q <= P_DIST;
          end else begin
            st_q <= P_NUM;
          end
        end
        P_NUM: begin
          sc_q <= sc_q + STEP_W'(1);
          if (sc_q == STEP_W'(4)) begin
            sc_q <= '0;
            dc_q <= '0;
            st_q <= P_DIV;
          end
        end
        P_DIV: begin
          dc_q <= dc_q + DIV_CNT_W'(1);
          if (dc_q == DIV_CNT_W'(QUOT_W - 1)) begin
            st_q <= P_RND;
          end
        end
        P_RND: st_q <= P_ADD;
        P_ADD: st_q <= P_DIST;
        P_DIST: begin
          sc_q <= sc_q + STEP_W'(1);
          if (sc_q == STEP_W'(2)) begin
            sc_q   <= '0;
            done_q <= 1'b1;
            st_q   <= P_IDLE;
          end
        end
        default: st_q <= P_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      P_IDLE: begin
        if (start_i) begin
          ax_q <= DIFF_W'(seg_i.ax);
          ay_q <= DIFF_W'(seg_i.ay);
          bx_q <= DIFF_W'(seg_i.bx);
          by_q <= DIFF_W'(seg_i.by);
          dx_q <= DIFF_W'(seg_i.bx) - DIFF_W'(seg_i.ax);
          dy_q <= DIFF_W'(seg_i.by) - DIFF_W'(seg_i.ay);
          ux_q <= DIFF_W'(px_i) - DIFF_W'(seg_i.ax);
          uy_q <= DIFF_W'(py_i) - DIFF_W'(seg_i.ay);
        end
      end
      P_MUL: begin
        unique case (sc_q)
          3'd1:    len2_q <= prod_q[LEN_W-1:0];
          3'd2:    len2_q <= len2_q + prod_q[LEN_W-1:0];
          3'd3:    dot_q  <= prod_q;
          3'd4:    dot_q  <= dot_q + prod_q;
          default: ;
        endcase
      end
      P_CHK: begin
        // start point unless strictly inside, then end point if past it
        nx_q <= ax_q;
        ny_q <= ay_q;
        if (len2_q != '0 && !dot_q[DOT_W-1] && dot_q != '0 &&
            $unsigned(dot_q) >= DOT_W'(len2_q)) begin
          nx_q <= bx_q;
          ny_q <= by_q;
        end
      end
      P_NUM: begin
        unique case (sc_q)
          3'd1: remx_q <= NUM_W'(prod_q[2*DIFF_W-1:0]);
          3'd2: remx_q <= remx_q + {prod_q[2*DIFF_W-1:0], {DIFF_W{1'b0}}};
          3'd3: remy_q <= NUM_W'(prod_q[2*DIFF_W-1:0]);
          3'd4: begin
            remy_q <= remy_q + {prod_q[2*DIFF_W-1:0], {DIFF_W{1'b0}}};
            dv_q   <= {len2_q, {(QUOT_W-1){1'b0}}};
            qx_q   <= '0;
            qy_q   <= '0;
          end
          default: ;
        endcase
      end
      P_DIV: begin
        if (gex) remx_q <= remx_q - dv_q;
        if (gey) remy_q <= remy_q - dv_q;
        qx_q <= {qx_q[QUOT_W-2:0], gex};
        qy_q <= {qy_q[QUOT_W-2:0], gey};
        dv_q <= dv_q >> 1;
      end
      P_RND: begin
        // round half up in magnitude
        qx_q <= qx_q + QUOT_W'({remx_q, 1'b0} >= (NUM_W+1)'(len2_q));
        qy_q <= qy_q + QUOT_W'({remy_q, 1'b0} >= (NUM_W+1)'(len2_q));
      end
      P_ADD: begin
        nx_q <= dx_q[DIFF_W-1] ? ax_q - $signed(qx_q) : ax_q + $signed(qx_q);
        ny_q <= dy_q[DIFF_W-1] ? ay_q - $signed(qy_q) : ay_q + $signed(qy_q);
      end
      P_DIST: begin
        unique case (sc_q)
          3'd1:    d2_q <= prod_q[LEN_W-1:0];
          3'd2:    d2_q <= d2_q + prod_q[LEN_W-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.near_x = nx_q;
  assign rsp_o.near_y = ny_q;
  assign rsp_o.dist2  = d2_q;

endmodule

`default_nettype wire

### rtl/core/nearest_segment_search.sv
// Top level of the nearest segment search block: request handling, table
// control and result register. Depends on nss_pkg, nss_if, nss_seg_mem, nss_proj.
//
//   channel | dir | handshake     | carries
//   in_i    | in  | valid/ready   | kind, first_x/y, second_x/y
//   out_o   | out | valid/ready   | near point, indices, status flags
//   cfg_i   | in  | valid/ready   | distance_limit
//
// Clear and append requests complete when accepted. A query reads each of the
// N stored segments from the table in turn and projects the query point onto
// it with one shared 34x34 multiplier and a one bit per cycle divider; the
// divider runs only when the projection falls inside the segment, not when it
// clamps to an end. Reset clears the count and the overflow flag and
// restores the limit to 1000000; table contents are not cleared. A held result
// does not stop the next request being taken; a finished query waits only for
// the result register.
`default_nettype none

module nearest_segment_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  nss_in_if.sink        in_i,
  nss_out_if.source     out_o,
  nss_cfg_if.sink       cfg_i
);
  import nss_pkg::*;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_READ  = 5'b00010,
    T_START = 5'b00100,
    T_WAIT  = 5'b01000,
    T_DONE  = 5'b10000
  } tstate_e;

  tstate_e                   st_q;
  logic [CNT_W-1:0]          count_q;
  logic [IDX_W-1:0]          idx_q;
  logic                      ovf_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic signed [COORD_W-1:0] px_q, py_q, bestx_q, besty_q;
  logic [LEN_W-1:0]          best_q;
  logic [IDX_W-1:0]          near_idx_q, exact_idx_q;
  logic                      found_q, exact_q, empty_q;
  logic                      out_valid_q;
  logic [2*LIMIT_W-1:0]      lim_sq;
  logic                      in_acc, mem_we, mem_re, last_seg, out_load;
  seg_t                      wseg, rseg;
  proj_rsp_t                 prsp;

  assign in_i.ready  = (st_q == T_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign lim_sq      = limit_q * limit_q;

  // drop appends to a full table
  assign mem_we = in_acc && (in_i.kind == KIND_APPEND) && (count_q < CNT_W'(MAX_SEGMENTS));
  assign wseg   = '{by: in_i.second_y, bx: in_i.second_x, ay: in_i.first_y, ax: in_i.first_x};
  assign mem_re = (st_q == T_READ);

  assign last_seg = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign out_load = (st_q == T_DONE) && (!out_valid_q || out_o.ready);

  nss_seg_mem u_seg_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wseg),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (rseg)
  );

  nss_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == T_START),
    .seg_i   (rseg),
    .px_i    (px_q),
    .py_i    (py_q),
    .rsp_o   (prsp)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.distance_limit;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        T_IDLE: begin
          if (in_acc) begin
            priority if (in_i.kind == KIND_CLEAR) begin
              count_q <= '0;
            end else if (in_i.kind == KIND_APPEND) begin
              if (mem_we) count_q <= count_q + CNT_W'(1);
              else        ovf_q   <= 1'b1;
            end else if (in_i.kind == KIND_QUERY) begin
              idx_q <= '0;
              st_q  <= (count_q == '0) ? T_DONE : T_READ;
            end else begin
              st_q <= T_IDLE;
            end
          end
        end
        T_READ:  st_q <= T_START;
        T_START: st_q <= T_WAIT;
        T_WAIT: begin
          if (prsp.done) begin
            if (last_seg) begin
              st_q <= T_DONE;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
              st_q  <= T_READ;
            end
          end
        end
        T_DONE: begin
          if (out_load) st_q <= T_IDLE;
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  // query bookkeeping: best so far and first exact hit
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.kind == KIND_QUERY) begin
      px_q        <= in_i.first_x;
      py_q        <= in_i.first_y;
      best_q      <= LEN_W'({lim_sq, 16'b0});
      found_q     <= 1'b0;
      exact_q     <= 1'b0;
      near_idx_q  <= '0;
      exact_idx_q <= '0;
      empty_q     <= (count_q == '0);
    end else if (st_q == T_WAIT && prsp.done) begin
      if (!exact_q && prsp.dist2 == '0) begin
        exact_q     <= 1'b1;
        exact_idx_q <= idx_q;
      end
      // later segment wins a tie
      if (prsp.dist2 <= best_q) begin
        best_q     <= prsp.dist2;
        bestx_q    <= prsp.near_x[COORD_W-1:0];
        besty_q    <= prsp.near_y[COORD_W-1:0];
        near_idx_q <= idx_q;
        found_q    <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.near_x       <= empty_q ? px_q : (found_q ? bestx_q : NO_POINT);
      out_o.near_y       <= empty_q ? py_q : (found_q ? besty_q : NO_POINT);
      out_o.near_index   <= OUT_IDX_W'(near_idx_q);
      out_o.exact_index  <= OUT_IDX_W'(exact_idx_q);
      out_o.exact_found  <= exact_q;
      out_o.table_empty  <= empty_q;
      out_o.beyond_limit <= !empty_q && !found_q;
      out_o.overflowed   <= ovf_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/nss_checker.sv
// Port-level checks on the result channel of nearest_segment_search, and the
// bind that attaches them. Depends on nss_pkg.
`default_nettype none

module nss_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [nss_pkg::COORD_W-1:0] near_x_i,
  input  logic signed [nss_pkg::COORD_W-1:0] near_y_i,
  input  logic [nss_pkg::OUT_IDX_W-1:0]      near_index_i,
  input  logic [nss_pkg::OUT_IDX_W-1:0]      exact_index_i,
  input  logic                               exact_found_i,
  input  logic                               table_empty_i,
  input  logic                               beyond_limit_i
);
  import nss_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(near_x_i) && $stable(near_y_i))
    else $error("result changed while stalled");

  // empty table echoes and reports nothing else
  a_empty_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && table_empty_i |-> !beyond_limit_i && !exact_found_i &&
    near_index_i == '0 && exact_index_i == '0)
    else $error("empty table result carries flags");

  // nothing within the limit gives the no-point marker
  a_beyond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && beyond_limit_i |-> near_x_i == NO_POINT && near_y_i == NO_POINT &&
    near_index_i == '0 && !exact_found_i)
    else $error("beyond-limit result malformed");

  // no exact hit leaves index zero
  a_exact_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !exact_found_i |-> exact_index_i == '0)
    else $error("exact index set without exact hit");

endmodule

bind nearest_segment_search nss_checker u_nss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .near_x_i       (out_o.near_x),
  .near_y_i       (out_o.near_y),
  .near_index_i   (out_o.near_index),
  .exact_index_i  (out_o.exact_index),
  .exact_found_i  (out_o.exact_found),
  .table_empty_i  (out_o.table_empty),
  .beyond_limit_i (out_o.beyond_limit)
);

`default_nettype wire
